### rtl/tcw_pkg.sv
// Package for the text console writer: word types, codes and the
// controller/datapath command and status structs.
// No dependencies.
package tcw_pkg;

   localparam logic [1:0] MODE_PUT   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [7:0] CODE_NUL = 8'd0;
   localparam logic [7:0] CODE_BS  = 8'd8;
   localparam logic [7:0] CODE_TAB = 8'd9;
   localparam logic [7:0] CODE_LF  = 8'd10;
   localparam logic [7:0] CODE_CR  = 8'd13;
   localparam logic [7:0] BLANK    = 8'h20;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  char_code;
      logic [7:0]  color;
      logic        use_color;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic        scrolled;
      logic [7:0]  read_char;
      logic [7:0]  read_attr;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_NEWLINE,
      OP_TAB,
      OP_CR,
      OP_BS,
      OP_PRINT,
      OP_CLEAR,
      OP_READ
   } op_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_INC,
      CUR_DEC,
      CUR_LINE,
      CUR_TAB,
      CUR_HOME,
      CUR_LAST_ROW
   } cur_op_type;

   typedef struct packed {
      logic       load;
      logic       mod_start;
      cur_op_type cur_op;
      logic       put_char;
      logic       put_blank;
      logic       read_cell;
      logic       clear_start;
      logic       scroll_start;
      logic       result_load;
   } ctl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   cursor_zero;
      logic   cursor_over;
      logic   mod_busy;
      logic   sweep_busy;
   } ctl_status_type;

endpackage

### rtl/text_console_writer.sv
// Text console writer: top level joining the controller and the datapath.
// Depends on tcw_pkg, tcw_controller, tcw_datapath.
//
// One word is handled at a time; req_ready is high only while the block is
// idle, and a finished result waits in the output register without holding
// off the next request, though the next result is held until that one is
// taken. NUL and the unused mode go from decode straight to the result
// register; a printable character, carriage return or backspace passes a
// check for scrolling first, and a read waits for the memory read. Newline and
// tab first wait for the remainder of the cursor, found by reciprocal
// multiplication. A scroll and a clear sweep the whole screen, moving or
// filling one cell a cycle through the single write port of each memory.
// Software must clear the screen before reading it; the block itself does
// not enforce this.
module text_console_writer #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcw_pkg::rsp_type rsp_data
);

   tcw_pkg::ctl_cmd_type    cmd;
   tcw_pkg::ctl_status_type status;

   tcw_controller u_ctl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   tcw_datapath #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_WIDTH(TAB_WIDTH)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .cmd     (cmd),
      .status  (status),
      .rsp_data(rsp_data)
   );

endmodule

### rtl/tcw_mod_unit.sv
// Remainder unit: value mod a constant divisor by reciprocal multiplication,
// quotient registered first and the remainder in the next cycle.
// Standalone, no package dependency.
module tcw_mod_unit #(
   parameter int VALUE_WIDTH = 12,
   parameter int DIVISOR     = 80,
   parameter int REM_WIDTH   = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] value,
   output logic                   busy,
   output logic [REM_WIDTH-1:0]   remainder
);

   localparam int     SHIFT       = VALUE_WIDTH + $clog2(DIVISOR);
   localparam longint RECIP       = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                                    / longint'(DIVISOR);
   localparam int     RECIP_WIDTH = $clog2(RECIP + 1);
   localparam int     PROD_WIDTH  = VALUE_WIDTH + RECIP_WIDTH;

   localparam logic [RECIP_WIDTH-1:0] RECIP_VEC = RECIP_WIDTH'(RECIP);
   localparam logic [VALUE_WIDTH-1:0] DIV_VEC   = VALUE_WIDTH'(DIVISOR);

   logic [1:0]             cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [REM_WIDTH-1:0]   rem_ff, rem_in;
   logic [PROD_WIDTH-1:0]  product;
   logic [VALUE_WIDTH-1:0] back;

   always_comb begin
      product = PROD_WIDTH'(val_ff) * PROD_WIDTH'(RECIP_VEC);
      back    = quot_ff * DIV_VEC;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         cnt_in = 2'd2;
         val_in = value;
      end else if (cnt_ff == 2'd2) begin
         cnt_in  = 2'd1;
         quot_in = VALUE_WIDTH'(product >> SHIFT);
      end else if (cnt_ff == 2'd1) begin
         cnt_in = 2'd0;
         rem_in = REM_WIDTH'(val_ff - back);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      val_ff  <= val_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign busy      = (cnt_ff != '0);
   assign remainder = rem_ff;

endmodule

### rtl/tcw_datapath.sv
// Datapath: item register, cursor, character and attribute memories, sweep
// engine for clear and scroll, result register.
// Depends on tcw_pkg and tcw_mod_unit.
module tcw_datapath #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcw_pkg::req_type         req_data,
   input  tcw_pkg::ctl_cmd_type     cmd,
   output tcw_pkg::ctl_status_type  status,
   output tcw_pkg::rsp_type         rsp_data
);

   localparam int CELLS   = COLUMNS * ROWS;
   localparam int AW      = $clog2(CELLS);
   localparam int CW      = $clog2(CELLS + TAB_WIDTH);
   localparam int MOD_MAX = (COLUMNS > TAB_WIDTH) ? COLUMNS : TAB_WIDTH;
   localparam int MW      = $clog2(MOD_MAX + 1);

   tcw_pkg::req_type item_ff;
   tcw_pkg::rsp_type rsp_ff;
   tcw_pkg::op_type  op;

   logic [CW-1:0] cursor_ff, cursor_in;
   logic          scrolled_ff;
   logic          in_range;

   logic [7:0] char_mem_ff [CELLS];
   logic [7:0] attr_mem_ff [CELLS];
   logic [7:0] char_q_ff, attr_q_ff;

   logic          sweep_active_ff, sweep_clear_ff;
   logic [AW-1:0] sweep_ptr_ff;
   logic          move_pend_ff, move_src_ff;
   logic [AW-1:0] move_addr_ff;
   logic          scroll_step, scroll_src;

   logic          char_we, attr_we, rd_en;
   logic [AW-1:0] char_wa, attr_wa, rd_addr;
   logic [7:0]    char_wd, attr_wd;

   logic [MW-1:0] col_rem, tab_rem, remainder;
   logic          col_busy, tab_busy, mod_busy;

   always_comb begin
      op = tcw_pkg::OP_NONE;
      unique case (item_ff.mode)
         tcw_pkg::MODE_PUT: begin
            unique case (item_ff.char_code)
               tcw_pkg::CODE_NUL: op = tcw_pkg::OP_NONE;
               tcw_pkg::CODE_LF:  op = tcw_pkg::OP_NEWLINE;
               tcw_pkg::CODE_TAB: op = tcw_pkg::OP_TAB;
               tcw_pkg::CODE_CR:  op = tcw_pkg::OP_CR;
               tcw_pkg::CODE_BS:  op = tcw_pkg::OP_BS;
               default:           op = tcw_pkg::OP_PRINT;
            endcase
         end
         tcw_pkg::MODE_CLEAR: op = tcw_pkg::OP_CLEAR;
         tcw_pkg::MODE_READ:  op = tcw_pkg::OP_READ;
         default:             op = tcw_pkg::OP_NONE;
      endcase
   end

   assign in_range = (32'(item_ff.cell_index) < CELLS);

   tcw_mod_unit #(
      .VALUE_WIDTH(CW),
      .DIVISOR    (COLUMNS),
      .REM_WIDTH  (MW)
   ) u_col_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mod_start),
      .value    (cursor_ff),
      .busy     (col_busy),
      .remainder(col_rem)
   );

   tcw_mod_unit #(
      .VALUE_WIDTH(CW),
      .DIVISOR    (TAB_WIDTH),
      .REM_WIDTH  (MW)
   ) u_tab_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mod_start),
      .value    (cursor_ff),
      .busy     (tab_busy),
      .remainder(tab_rem)
   );

   assign remainder = (op == tcw_pkg::OP_TAB) ? tab_rem : col_rem;
   assign mod_busy  = col_busy || tab_busy;

   always_comb begin
      unique case (cmd.cur_op)
         tcw_pkg::CUR_HOLD:     cursor_in = cursor_ff;
         tcw_pkg::CUR_INC:      cursor_in = cursor_ff + 1'b1;
         tcw_pkg::CUR_DEC:      cursor_in = cursor_ff - 1'b1;
         tcw_pkg::CUR_LINE:     cursor_in = cursor_ff - CW'(remainder) + CW'(COLUMNS);
         tcw_pkg::CUR_TAB:      cursor_in = cursor_ff + CW'(TAB_WIDTH) - CW'(remainder);
         tcw_pkg::CUR_HOME:     cursor_in = '0;
         tcw_pkg::CUR_LAST_ROW: cursor_in = CW'(CELLS - COLUMNS);
         default:               cursor_in = cursor_ff;
      endcase
   end

   assign scroll_step = sweep_active_ff && !sweep_clear_ff;
   assign scroll_src  = (sweep_ptr_ff < AW'(CELLS - COLUMNS));

   always_comb begin
      char_we = 1'b0;
      char_wa = AW'(cursor_ff);
      char_wd = item_ff.char_code;
      attr_we = 1'b0;
      attr_wa = AW'(cursor_ff);
      attr_wd = item_ff.color;
      priority if (move_pend_ff) begin
         char_we = 1'b1;
         char_wa = move_addr_ff;
         char_wd = move_src_ff ? char_q_ff : tcw_pkg::BLANK;
      end else if (sweep_active_ff && sweep_clear_ff) begin
         char_we = 1'b1;
         char_wa = sweep_ptr_ff;
         char_wd = tcw_pkg::BLANK;
         attr_we = 1'b1;
         attr_wa = sweep_ptr_ff;
      end else if (cmd.put_char) begin
         char_we = 1'b1;
         attr_we = item_ff.use_color;
      end else if (cmd.put_blank) begin
         char_we = 1'b1;
         char_wa = AW'(cursor_ff - 1'b1);
         char_wd = tcw_pkg::BLANK;
      end else begin
         char_we = 1'b0;
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = AW'(item_ff.cell_index);
      if (scroll_step) begin
         rd_en   = scroll_src;
         rd_addr = sweep_ptr_ff + AW'(COLUMNS);
      end else if (cmd.read_cell) begin
         rd_en = in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem_ff[char_wa] <= char_wd;
      end
      if (rd_en) begin
         char_q_ff <= char_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (attr_we) begin
         attr_mem_ff[attr_wa] <= attr_wd;
      end
      if (rd_en) begin
         attr_q_ff <= attr_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff       <= '0;
         sweep_active_ff <= 1'b0;
         move_pend_ff    <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         move_pend_ff <= scroll_step;
         if (cmd.clear_start || cmd.scroll_start) begin
            sweep_active_ff <= 1'b1;
         end else if (sweep_active_ff && (sweep_ptr_ff == AW'(CELLS - 1))) begin
            sweep_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_start || cmd.scroll_start) begin
         sweep_ptr_ff   <= '0;
         sweep_clear_ff <= cmd.clear_start;
      end else if (sweep_active_ff) begin
         sweep_ptr_ff <= sweep_ptr_ff + 1'b1;
      end
      move_addr_ff <= sweep_ptr_ff;
      move_src_ff  <= scroll_src;
      if (cmd.load) begin
         item_ff     <= req_data;
         scrolled_ff <= 1'b0;
      end else if (cmd.scroll_start) begin
         scrolled_ff <= 1'b1;
      end
      if (cmd.result_load) begin
         rsp_ff.cursor_position <= 11'(cursor_ff);
         rsp_ff.scrolled        <= scrolled_ff;
         if (op == tcw_pkg::OP_READ && in_range) begin
            rsp_ff.read_char <= char_q_ff;
            rsp_ff.read_attr <= attr_q_ff;
         end else begin
            rsp_ff.read_char <= 8'd0;
            rsp_ff.read_attr <= 8'd0;
         end
      end
   end

   assign status.op          = op;
   assign status.cursor_zero = (cursor_ff == '0);
   assign status.cursor_over = (cursor_ff >= CW'(CELLS));
   assign status.mod_busy    = mod_busy;
   assign status.sweep_busy  = sweep_active_ff || move_pend_ff;
   assign rsp_data           = rsp_ff;

endmodule

### rtl/tcw_controller.sv
// Controller: sequences one word at a time through decode, remainder,
// scroll/clear sweep and result hand-off.
// Depends on tcw_pkg.
module tcw_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tcw_pkg::ctl_status_type status,
   output tcw_pkg::ctl_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_MOD_WAIT,
      S_CHECK,
      S_SWEEP_WAIT,
      S_READ_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.cur_op = tcw_pkg::CUR_HOLD;
      state_in   = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.op)
               tcw_pkg::OP_NONE: state_in = S_FINISH;
               tcw_pkg::OP_NEWLINE, tcw_pkg::OP_TAB: begin
                  cmd.mod_start = 1'b1;
                  state_in      = S_MOD_WAIT;
               end
               tcw_pkg::OP_CR: begin
                  if (!status.cursor_zero) begin
                     cmd.cur_op = tcw_pkg::CUR_DEC;
                  end
                  state_in = S_CHECK;
               end
               tcw_pkg::OP_BS: begin
                  if (!status.cursor_zero) begin
                     cmd.cur_op    = tcw_pkg::CUR_DEC;
                     cmd.put_blank = 1'b1;
                  end
                  state_in = S_CHECK;
               end
               tcw_pkg::OP_PRINT: begin
                  cmd.put_char = 1'b1;
                  cmd.cur_op   = tcw_pkg::CUR_INC;
                  state_in     = S_CHECK;
               end
               tcw_pkg::OP_CLEAR: begin
                  cmd.clear_start = 1'b1;
                  cmd.cur_op      = tcw_pkg::CUR_HOME;
                  state_in        = S_SWEEP_WAIT;
               end
               tcw_pkg::OP_READ: begin
                  cmd.read_cell = 1'b1;
                  state_in      = S_READ_WAIT;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_MOD_WAIT: begin
            if (!status.mod_busy) begin
               cmd.cur_op = (status.op == tcw_pkg::OP_TAB) ? tcw_pkg::CUR_TAB
                                                           : tcw_pkg::CUR_LINE;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.cursor_over) begin
               cmd.scroll_start = 1'b1;
               cmd.cur_op       = tcw_pkg::CUR_LAST_ROW;
               state_in         = S_SWEEP_WAIT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SWEEP_WAIT: begin
            if (!status.sweep_busy) begin
               state_in = S_FINISH;
            end
         end
         S_READ_WAIT: state_in = S_FINISH;
         S_FINISH: begin
            if (rsp_free) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!status.mod_busy && !status.sweep_busy))
      else $error("unit busy while accepting a word");

   a_idle_cursor_in_screen: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.cursor_over)
      else $error("cursor off screen while idle");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_sweep_starts: assert property (@(posedge clock) disable iff (reset)
      (cmd.scroll_start || cmd.clear_start) |=> status.sweep_busy)
      else $error("sweep did not start");

   a_mod_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.mod_start |=> status.mod_busy)
      else $error("remainder unit did not start");
`endif

endmodule
